// ===== src/wbe_pkg.sv =====
package wbe_pkg;

	localparam int unsigned HalfWidth  = 8;
	localparam int unsigned LatchWidth = 10;
	localparam int unsigned CountWidth = 10;
	localparam int unsigned PhaseWidth = 3;
	localparam int unsigned BitIdxWidth = 3;
	localparam int unsigned CfgIdxWidth = 3;
	localparam int unsigned CfgDataWidth = 10;

	localparam logic [PhaseWidth-1:0] PH_IDLE  = 3'd0;
	localparam logic [PhaseWidth-1:0] PH_HIGH  = 3'd1;
	localparam logic [PhaseWidth-1:0] PH_LOW   = 3'd2;
	localparam logic [PhaseWidth-1:0] PH_GAP   = 3'd3;
	localparam logic [PhaseWidth-1:0] PH_LATCH = 3'd4;

	localparam logic [CfgIdxWidth-1:0] CFG_ZERO_HIGH = 3'd0;
	localparam logic [CfgIdxWidth-1:0] CFG_ZERO_LOW  = 3'd1;
	localparam logic [CfgIdxWidth-1:0] CFG_ONE_HIGH  = 3'd2;
	localparam logic [CfgIdxWidth-1:0] CFG_ONE_LOW   = 3'd3;
	localparam logic [CfgIdxWidth-1:0] CFG_LATCH     = 3'd4;

	localparam logic [HalfWidth-1:0]  ZERO_HIGH_RST = 8'd4;
	localparam logic [HalfWidth-1:0]  ZERO_LOW_RST  = 8'd8;
	localparam logic [HalfWidth-1:0]  ONE_HIGH_RST  = 8'd8;
	localparam logic [HalfWidth-1:0]  ONE_LOW_RST   = 8'd4;
	localparam logic [LatchWidth-1:0] LATCH_RST     = 10'd500;

	typedef struct packed {
		logic [HalfWidth-1:0]  zero_high_ticks;
		logic [HalfWidth-1:0]  zero_low_ticks;
		logic [HalfWidth-1:0]  one_high_ticks;
		logic [HalfWidth-1:0]  one_low_ticks;
		logic [LatchWidth-1:0] latch_ticks;
	} timing_t;

	typedef struct packed {
		logic underrun;
		logic frame_done;
		logic ready_for_byte;
		logic byte_accepted;
		logic line_level;
	} result_t;

endpackage

// ===== src/ws2812_bit_waveform_encoder.sv =====
// WS2812 bit waveform encoder. Each input transfer is either one waveform tick
// (tuser 0) or a byte push into a one-deep holding register (tuser 1, byte in
// tdata, tlast marks the last byte of a frame); each produces exactly one
// result transfer with the line level for that tick and status flags. Bytes go
// out MSB first using the programmed high/low tick counts, and after the last
// byte the line stays low for latch_ticks before frame_done pulses. The block
// takes one transfer per clock cycle: an input register feeds a single pass of
// next-state logic that lands in the result register; throughput is limited
// only by the result side accepting. The user writes timing registers through
// wr_en/wr_index/wr_data only while idle; the block does not enforce this.
module ws2812_bit_waveform_encoder (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [7:0]                       s_axis_tdata,  // data_byte
	input  logic                             s_axis_tuser,  // action
	input  logic                             s_axis_tlast,  // last_byte
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// line_level, byte_accepted, ready_for_byte, frame_done, underrun, zero pad
	output logic [7:0]                       m_axis_tdata,
	input  logic                             wr_en,
	input  logic [wbe_pkg::CfgIdxWidth-1:0]  wr_index,
	input  logic [wbe_pkg::CfgDataWidth-1:0] wr_data
);
	import wbe_pkg::*;

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       action_s1;
	logic       last_s1;
	logic       step_en;
	logic       out_valid_q;
	result_t    out_q;
	result_t    result;
	timing_t    timing;

	assign step_en       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || step_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			data_s1   <= s_axis_tdata;
			action_s1 <= s_axis_tuser;
			last_s1   <= s_axis_tlast;
		end
	end

	wbe_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.timing   (timing)
	);

	wbe_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (step_en),
		.action    (action_s1),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.timing    (timing),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_en) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			out_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_q};

endmodule

// ===== src/wbe_cfg_regs.sv =====
module wbe_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [wbe_pkg::CfgIdxWidth-1:0]  wr_index,
	input  logic [wbe_pkg::CfgDataWidth-1:0] wr_data,
	output wbe_pkg::timing_t                 timing
);
	import wbe_pkg::*;

	timing_t timing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_q.zero_high_ticks <= ZERO_HIGH_RST;
			timing_q.zero_low_ticks  <= ZERO_LOW_RST;
			timing_q.one_high_ticks  <= ONE_HIGH_RST;
			timing_q.one_low_ticks   <= ONE_LOW_RST;
			timing_q.latch_ticks     <= LATCH_RST;
		end else if (wr_en) begin
			case (wr_index)
				CFG_ZERO_HIGH: timing_q.zero_high_ticks <= wr_data[HalfWidth-1:0];
				CFG_ZERO_LOW:  timing_q.zero_low_ticks  <= wr_data[HalfWidth-1:0];
				CFG_ONE_HIGH:  timing_q.one_high_ticks  <= wr_data[HalfWidth-1:0];
				CFG_ONE_LOW:   timing_q.one_low_ticks   <= wr_data[HalfWidth-1:0];
				CFG_LATCH:     timing_q.latch_ticks     <= wr_data[LatchWidth-1:0];
				default: begin
				end
			endcase
		end
	end

	assign timing = timing_q;

endmodule

// ===== src/wbe_core.sv =====
module wbe_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step_en,
	input  logic             action,
	input  logic [7:0]       data_byte,
	input  logic             last_byte,
	input  wbe_pkg::timing_t timing,
	output wbe_pkg::result_t result
);
	import wbe_pkg::*;

	logic [PhaseWidth-1:0]  phase_q, phase_d;
	logic [7:0]             shift_q, shift_d;
	logic [BitIdxWidth-1:0] bit_idx_q, bit_idx_d;
	logic [CountWidth-1:0]  count_q, count_d;
	logic                   cur_last_q, cur_last_d;
	logic [7:0]             hold_byte_q, hold_byte_d;
	logic                   hold_valid_q, hold_valid_d;
	logic                   hold_last_q, hold_last_d;
	logic [HalfWidth-1:0]   half_len;
	logic                   cur_bit;

	always_comb begin
		phase_d      = phase_q;
		shift_d      = shift_q;
		bit_idx_d    = bit_idx_q;
		count_d      = count_q;
		cur_last_d   = cur_last_q;
		hold_byte_d  = hold_byte_q;
		hold_valid_d = hold_valid_q;
		hold_last_d  = hold_last_q;
		result       = '0;
		cur_bit      = 1'b0;
		half_len     = '0;

		if (action) begin
			if (!hold_valid_q) begin
				hold_byte_d          = data_byte;
				hold_last_d          = last_byte;
				hold_valid_d         = 1'b1;
				result.byte_accepted = 1'b1;
			end
			result.line_level = (phase_q == PH_HIGH);
			result.underrun   = (phase_q == PH_GAP);
		end else begin
			// a waiting byte starts at once, this tick is its first high tick
			if ((phase_q == PH_IDLE || phase_q == PH_GAP) && hold_valid_q) begin
				shift_d      = hold_byte_q;
				cur_last_d   = hold_last_q;
				hold_valid_d = 1'b0;
				bit_idx_d    = 3'd7;
				count_d      = '0;
				phase_d      = PH_HIGH;
			end
			cur_bit = shift_d[bit_idx_d];
			case (phase_d)
				PH_HIGH: begin
					half_len          = cur_bit ? timing.one_high_ticks : timing.zero_high_ticks;
					result.line_level = 1'b1;
					count_d           = count_d + 10'd1;
					if (count_d >= {2'b00, half_len}) begin
						count_d = '0;
						phase_d = PH_LOW;
					end
				end
				PH_LOW: begin
					half_len = cur_bit ? timing.one_low_ticks : timing.zero_low_ticks;
					count_d  = count_d + 10'd1;
					if (count_d >= {2'b00, half_len}) begin
						count_d = '0;
						if (bit_idx_d == 3'd0) begin
							phase_d = cur_last_d ? PH_LATCH : PH_GAP;
						end else begin
							bit_idx_d = bit_idx_d - 3'd1;
							phase_d   = PH_HIGH;
						end
					end
				end
				PH_GAP: begin
					result.underrun = 1'b1;
				end
				PH_LATCH: begin
					count_d = count_d + 10'd1;
					if (count_d >= timing.latch_ticks) begin
						count_d           = '0;
						result.frame_done = 1'b1;
						phase_d           = PH_IDLE;
					end
				end
				PH_IDLE: begin
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
		result.ready_for_byte = !hold_valid_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			shift_q      <= '0;
			bit_idx_q    <= '0;
			count_q      <= '0;
			cur_last_q   <= 1'b0;
			hold_valid_q <= 1'b0;
			hold_last_q  <= 1'b0;
		end else if (step_en) begin
			phase_q      <= phase_d;
			shift_q      <= shift_d;
			bit_idx_q    <= bit_idx_d;
			count_q      <= count_d;
			cur_last_q   <= cur_last_d;
			hold_valid_q <= hold_valid_d;
			hold_last_q  <= hold_last_d;
		end
	end

	// holding byte is only read while its valid flag is set
	always_ff @(posedge clk) begin
		if (step_en) begin
			hold_byte_q <= hold_byte_d;
		end
	end

endmodule

// ===== src/wbe_checker.sv =====
module wbe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tready,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata
);

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// input side only stalls behind a blocked result
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output back-pressure");

	// an accepted byte leaves the holding register full
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1] |-> !m_axis_tdata[2])
		else $error("byte accepted but holding register reported empty");

	// latch end and underrun exclude each other
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[3] && m_axis_tdata[4]))
		else $error("frame_done together with underrun");

endmodule

bind ws2812_bit_waveform_encoder wbe_checker u_wbe_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ===== verif/waveform_checker.sv =====
`timescale 1ns / 1ps
module waveform_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	input  logic                             s_axis_tready,
	input  logic [7:0]                       s_axis_tdata,  // data_byte
	input  logic                             s_axis_tuser,  // action
	input  logic                             s_axis_tlast,  // last_byte
	input  logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// line_level, byte_accepted, ready_for_byte, frame_done, underrun, zero pad
	input  logic [7:0]                       m_axis_tdata,
	input  logic                             wr_en,
	input  logic [wbe_pkg::CfgIdxWidth-1:0]  wr_index,
	input  logic [wbe_pkg::CfgDataWidth-1:0] wr_data,
	output int                               mismatches,
	output int                               results_due
);
	import wbe_pkg::*;

	timing_t                 timing;
	logic [PhaseWidth-1:0]   phase;
	logic [7:0]              shifter;
	logic [BitIdxWidth-1:0]  bit_pos;
	logic [CountWidth-1:0]   ticks;
	logic                    frame_end;
	logic [7:0]              held_byte;
	logic                    held_valid;
	logic                    held_last;
	result_t                 line_results[$];

	function automatic logic [HalfWidth-1:0] half_ticks(input logic high_half);
		if (shifter[bit_pos])
			return high_half ? timing.one_high_ticks : timing.one_low_ticks;
		return high_half ? timing.zero_high_ticks : timing.zero_low_ticks;
	endfunction

	function automatic result_t encode_step(input logic push, input logic [7:0] din,
		input logic lst);
		result_t r;
		r = '0;
		if (push) begin
			if (!held_valid) begin
				held_byte = din;
				held_last = lst;
				held_valid = 1'b1;
				r.byte_accepted = 1'b1;
			end
			r.line_level = (phase == PH_HIGH);
			r.underrun = (phase == PH_GAP);
		end else begin
			// a waiting byte starts on this very tick
			if ((phase == PH_IDLE || phase == PH_GAP) && held_valid) begin
				shifter = held_byte;
				frame_end = held_last;
				held_valid = 1'b0;
				bit_pos = 3'd7;
				ticks = '0;
				phase = PH_HIGH;
			end
			case (phase)
				PH_HIGH: begin
					r.line_level = 1'b1;
					ticks = ticks + 1'b1;
					if (ticks >= half_ticks(1'b1)) begin
						ticks = '0;
						phase = PH_LOW;
					end
				end
				PH_LOW: begin
					ticks = ticks + 1'b1;
					if (ticks >= half_ticks(1'b0)) begin
						ticks = '0;
						if (bit_pos == '0) begin
							phase = frame_end ? PH_LATCH : PH_GAP;
						end else begin
							bit_pos = bit_pos - 1'b1;
							phase = PH_HIGH;
						end
					end
				end
				PH_GAP: r.underrun = 1'b1;
				PH_LATCH: begin
					ticks = ticks + 1'b1;
					if (ticks >= timing.latch_ticks) begin
						ticks = '0;
						r.frame_done = 1'b1;
						phase = PH_IDLE;
					end
				end
				default: phase = PH_IDLE;
			endcase
		end
		r.ready_for_byte = !held_valid;
		return r;
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		result_t want;
		result_t got;
		if (!arst_n) begin
			timing.zero_high_ticks = ZERO_HIGH_RST;
			timing.zero_low_ticks = ZERO_LOW_RST;
			timing.one_high_ticks = ONE_HIGH_RST;
			timing.one_low_ticks = ONE_LOW_RST;
			timing.latch_ticks = LATCH_RST;
			phase = PH_IDLE;
			shifter = '0;
			bit_pos = '0;
			ticks = '0;
			frame_end = 1'b0;
			held_byte = '0;
			held_valid = 1'b0;
			held_last = 1'b0;
			line_results.delete();
			mismatches = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (line_results.size() == 0) begin
					$error("result transfer with nothing outstanding: tdata %h", m_axis_tdata);
					mismatches++;
				end else begin
					want = line_results.pop_front();
					got = result_t'(m_axis_tdata[4:0]);
					check_field("line_level", int'(want.line_level), int'(got.line_level));
					check_field("byte_accepted", int'(want.byte_accepted),
						int'(got.byte_accepted));
					check_field("ready_for_byte", int'(want.ready_for_byte),
						int'(got.ready_for_byte));
					check_field("frame_done", int'(want.frame_done), int'(got.frame_done));
					check_field("underrun", int'(want.underrun), int'(got.underrun));
					check_field("tdata pad", 0, int'(m_axis_tdata[7:5]));
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				line_results.push_back(encode_step(s_axis_tuser, s_axis_tdata, s_axis_tlast));
			if (wr_en) begin
				case (wr_index)
					CFG_ZERO_HIGH: timing.zero_high_ticks = wr_data[HalfWidth-1:0];
					CFG_ZERO_LOW:  timing.zero_low_ticks = wr_data[HalfWidth-1:0];
					CFG_ONE_HIGH:  timing.one_high_ticks = wr_data[HalfWidth-1:0];
					CFG_ONE_LOW:   timing.one_low_ticks = wr_data[HalfWidth-1:0];
					CFG_LATCH:     timing.latch_ticks = wr_data[LatchWidth-1:0];
					default: ;
				endcase
			end
		end
		results_due = line_results.size();
	end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
module tb;
	import wbe_pkg::*;

	localparam logic                   ACT_TICK = 1'b0;
	localparam logic                   ACT_PUSH = 1'b1;
	localparam logic [CfgIdxWidth-1:0] CFG_NONE = 3'd7;
	localparam int RANDOM_ITEMS  = 240;
	localparam int RANDOM_SPLIT  = 4;
	localparam int LONG_HOLD     = 64;
	localparam int SETTLE_CYCLES = 4;
	localparam int QUIET_LIMIT   = 2000;

	logic                    clk;
	logic                    arst_n;
	logic                    s_axis_tvalid;
	logic                    s_axis_tready;
	logic [7:0]              s_axis_tdata;  // data_byte
	logic                    s_axis_tuser;  // action
	logic                    s_axis_tlast;  // last_byte
	logic                    m_axis_tvalid;
	logic                    m_axis_tready;
	// line_level, byte_accepted, ready_for_byte, frame_done, underrun, zero pad
	logic [7:0]              m_axis_tdata;
	logic                    wr_en;
	logic [CfgIdxWidth-1:0]  wr_index;
	logic [CfgDataWidth-1:0] wr_data;
	int                      mismatches;
	int                      results_due;
	int                      sent;
	logic                    calm;
	logic                    stall_req;
	timing_t                 timing;

	ws2812_bit_waveform_encoder u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data)
	);

	waveform_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.mismatches    (mismatches),
		.results_due   (results_due)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic int byte_ticks(input logic [7:0] b);
		int n;
		n = 0;
		for (int i = 0; i < 8; i++) begin
			if (b[i])
				n += int'(timing.one_high_ticks) + int'(timing.one_low_ticks);
			else
				n += int'(timing.zero_high_ticks) + int'(timing.zero_low_ticks);
		end
		return n;
	endfunction

	task automatic push_item(input logic act, input logic [7:0] b, input logic lst);
		int gap;
		gap = pause_len();
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= act;
		s_axis_tdata <= b;
		s_axis_tlast <= lst;
		do @(posedge clk); while (!s_axis_tready);
		sent++;
	endtask

	task automatic send_ticks(input int n);
		repeat (n) push_item(ACT_TICK, 8'($urandom), 1'($urandom));
	endtask

	task automatic settle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (results_due != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic program_timing(input int zh, input int zl, input int oh, input int ol,
		input int lt);
		timing.zero_high_ticks = HalfWidth'(zh);
		timing.zero_low_ticks = HalfWidth'(zl);
		timing.one_high_ticks = HalfWidth'(oh);
		timing.one_low_ticks = HalfWidth'(ol);
		timing.latch_ticks = LatchWidth'(lt);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= CFG_ZERO_HIGH;
		wr_data <= CfgDataWidth'(zh);
		@(negedge clk);
		wr_index <= CFG_ZERO_LOW;
		wr_data <= CfgDataWidth'(zl);
		@(negedge clk);
		wr_index <= CFG_ONE_HIGH;
		wr_data <= CfgDataWidth'(oh);
		@(negedge clk);
		wr_index <= CFG_ONE_LOW;
		wr_data <= CfgDataWidth'(ol);
		@(negedge clk);
		wr_index <= CFG_LATCH;
		wr_data <= CfgDataWidth'(lt);
		// unmapped index, must leave the timing alone
		@(negedge clk);
		wr_index <= CFG_NONE;
		wr_data <= CfgDataWidth'($urandom);
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	// mostly back-to-back bytes with exact tick counts, sometimes early or late
	task automatic send_frame(input int nbytes);
		int owed;
		int d;
		int k;
		logic [7:0] b;
		owed = 0;
		for (int i = 0; i < nbytes; i++) begin
			b = 8'($urandom);
			push_item(ACT_PUSH, b, i == nbytes - 1);
			if ($urandom_range(0, 19) == 0)
				push_item(ACT_PUSH, 8'($urandom), 1'($urandom));
			d = byte_ticks(b);
			case ($urandom_range(0, 9))
				0: k = owed + d + $urandom_range(1, 4);
				1: k = $urandom_range(owed + 1, owed + d);
				default: k = owed + d;
			endcase
			if (i == nbytes - 1)
				k = owed + d + int'(timing.latch_ticks) + $urandom_range(0, 3);
			send_ticks(k);
			owed = owed + d - k;
			if (owed < 0)
				owed = 0;
		end
	endtask

	task automatic send_noise(input int n);
		int worst;
		worst = int'(timing.zero_high_ticks) + int'(timing.zero_low_ticks);
		if (int'(timing.one_high_ticks) + int'(timing.one_low_ticks) > worst)
			worst = int'(timing.one_high_ticks) + int'(timing.one_low_ticks);
		repeat (n) push_item(1'($urandom), 8'($urandom), 1'($urandom));
		// let whatever got in drain out
		send_ticks(16 * worst + int'(timing.latch_ticks) + 4);
	endtask

	initial begin : sink
		int n;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (stall_req) begin
				stall_req = 1'b0;
				n = LONG_HOLD;
			end else begin
				n = pause_len();
			end
			if (n > 0) begin
				m_axis_tready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb: errors");
		$finish;
	end

	initial begin : stimulus
		int goal;
		int hmax;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = ACT_TICK;
		s_axis_tlast = 1'b0;
		wr_en = 1'b0;
		wr_index = CFG_ZERO_HIGH;
		wr_data = '0;
		calm = 1'b0;
		stall_req = 1'b0;
		sent = 0;
		timing = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// shortest timing: idle tick, drop on full, underrun in gap, latch and done
		program_timing(1, 1, 1, 1, 1);
		send_ticks(1);
		push_item(ACT_PUSH, 8'h00, 1'b0);
		push_item(ACT_PUSH, 8'hff, 1'b1);
		send_ticks(18);
		push_item(ACT_PUSH, 8'hff, 1'b1);
		push_item(ACT_PUSH, 8'h00, 1'b0);
		send_ticks(18);
		settle();

		for (int p = 0; p < RANDOM_SPLIT; p++) begin
			hmax = (p == RANDOM_SPLIT - 1) ? 8 : 4;
			program_timing($urandom_range(1, hmax), $urandom_range(1, hmax),
				$urandom_range(1, hmax), $urandom_range(1, hmax), $urandom_range(1, 16));
			calm = (p == 2);
			stall_req = (p == 1);
			goal = sent + RANDOM_ITEMS / RANDOM_SPLIT;
			while (sent < goal) begin
				if ($urandom_range(0, 9) == 0)
					send_noise($urandom_range(2, 8));
				send_frame($urandom_range(1, 4));
			end
			settle();
			calm = 1'b0;
		end

		// full-width half period on the leading zero bit
		program_timing(255, 1, 1, 1, 1);
		push_item(ACT_PUSH, 8'h7f, 1'b1);
		send_ticks(byte_ticks(8'h7f) + 3);
		settle();

		if (mismatches == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

// ===== sim.f =====
src/wbe_pkg.sv
src/wbe_cfg_regs.sv
src/wbe_core.sv
src/ws2812_bit_waveform_encoder.sv
src/wbe_checker.sv
verif/waveform_checker.sv
verif/tb.sv
